FILE: sv/k_way_run_merger_macros.svh
// Assertion macros shared by the merger RTL.
// Expects i_clk and i_rst_n in the including module's scope.
`ifndef K_WAY_RUN_MERGER_MACROS_SVH
`define K_WAY_RUN_MERGER_MACROS_SVH

// property that must hold at every edge out of reset
`define KWRM_ASSERT_ALW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("kwrm assertion failed");

// same-cycle implication
`define KWRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kwrm assertion failed");

// next-cycle implication
`define KWRM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kwrm assertion failed");

`endif

FILE: sv/kwrm_pkg.sv
// Package for the k-way run merger: field widths, candidate type, pick function.
// No dependencies.
package kwrm_pkg;

    localparam int IDX_W     = 4;
    localparam int VAL_W     = 64;
    localparam int CNT_W     = 5;
    localparam int MAX_SLOTS = 16;

    localparam logic [CNT_W-1:0] RUN_COUNT_RST = CNT_W'(16);

    // one head candidate in the minimum tree
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } t_cand;

    // a holds the lower run indices, so it wins ties
    function automatic t_cand kwrm_pick(input t_cand a, input t_cand b);
        t_cand r;
        if (a.vld && (!b.vld || (a.val <= b.val))) begin
            r = a;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

FILE: sv/kwrm_if.sv
// Valid/ready channel interfaces for the merger input and result streams.
// Depends on kwrm_pkg.
interface kwrm_in_if import kwrm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] run_index;
    logic [VAL_W-1:0] run_value;
    logic             exhausted;

    modport source (output valid, output run_index, output run_value, output exhausted,
                    input ready);
    modport sink   (input valid, input run_index, input run_value, input exhausted,
                    output ready);
endinterface

interface kwrm_out_if import kwrm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] out_value;
    logic [IDX_W-1:0] refill_run;
    logic             done_res;

    modport source (output valid, output out_value, output refill_run, output done_res,
                    input ready);
    modport sink   (input valid, input out_value, input refill_run, input done_res,
                    output ready);
endinterface

FILE: sv/kwrm_min_tree.sv
// Combinational minimum tree over the head words; ties go to the lower run.
// Depends on kwrm_pkg.
module kwrm_min_tree import kwrm_pkg::*; #(
    parameter int N_LEAF = 16
) (
    input  logic [N_LEAF-1:0] i_valid,
    input  logic [VAL_W-1:0]  i_word [N_LEAF],
    output t_cand             o_best
);

    localparam int LVL = (N_LEAF > 1) ? $clog2(N_LEAF) : 1;
    localparam int NP  = 1 << LVL;

    // heap layout: node 0 is the root, leaves at NP-1 .. 2*NP-2
    t_cand node [2*NP-1];

    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < N_LEAF) begin : g_real
            assign node[NP-1+j] = '{vld: i_valid[j], idx: IDX_W'(j), val: i_word[j]};
        end else begin : g_pad
            assign node[NP-1+j] = '0;
        end
    end

    for (genvar i = 0; i < NP-1; i++) begin : g_node
        assign node[i] = kwrm_pick(node[2*i+1], node[2*i+2]);
    end

    assign o_best = node[0];

endmodule

FILE: sv/k_way_run_merger.sv
// Top level of the k-way run merger: input stage, head registers, result register.
// Depends on kwrm_pkg, kwrm_if, kwrm_min_tree and k_way_run_merger_macros.svh.
//
//  channel  | dir | beat fields                          | handshake
//  ---------+-----+--------------------------------------+-------------
//  i_in     | in  | run_index, run_value, exhausted      | valid/ready
//  o_out    | out | out_value, refill_run, done_res      | valid/ready
//  i_cfg_*  | in  | run_count (5 bits)                   | write enable
//
// Pipeline: a beat taken at one edge is resolved from the input register in the next
//   cycle (head update + SLOTS-way min tree) and lands in the result register at the
//   following edge, where it is held until o_out.ready. One beat per cycle sustained
//   while results are taken.
// The min tree over the head registers is the long path of the design.
// Reset: synchronous, active low; clears head valid bits, fill count, awaited run,
//   stage valids, and sets run_count to 16. Head words are not reset.
// Stalls: a held result stops the resolve stage; the input register still takes
//   one more beat, after which i_in.ready drops.
`include "k_way_run_merger_macros.svh"

module k_way_run_merger import kwrm_pkg::*; #(
    parameter int RUNS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kwrm_in_if.sink           i_in,
    kwrm_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    // head slots: run_index is 4 bits, so never more than 16
    localparam int SLOTS = (RUNS < MAX_SLOTS) ? RUNS : MAX_SLOTS;

    // configuration and merge state
    logic [CNT_W-1:0] r_run_count;
    logic [SLOTS-1:0] r_valid;
    logic [VAL_W-1:0] r_word [SLOTS];
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_await;

    // input register
    logic             r_in_valid;
    logic [IDX_W-1:0] r_in_idx;
    logic [VAL_W-1:0] r_in_val;
    logic             r_in_exh;

    // result register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_val;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_done;

    logic             in_acc;
    logic             adv;        // resolve stage may move on this cycle
    logic [CNT_W-1:0] eff;        // run count clamped to 1 .. SLOTS
    logic             fill_ph;
    logic             in_rng;
    logic             wr;         // beat updates a head this cycle
    logic             emit;       // beat produces a result this cycle
    logic [CNT_W-1:0] fill_inc;
    logic [SLOTS-1:0] n_valid;
    logic [VAL_W-1:0] n_word [SLOTS];
    logic [SLOTS-1:0] lane_on;
    t_cand            best;

    // ---------------- handshakes ----------------
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;
    assign in_acc     = i_in.valid && i_in.ready;

    // ---------------- run count clamp ----------------
    always_comb begin
        priority if (r_run_count == '0) begin
            eff = CNT_W'(1);
        end else if (r_run_count > CNT_W'(SLOTS)) begin
            eff = CNT_W'(SLOTS);
        end else begin
            eff = r_run_count;
        end
    end

    // ---------------- resolve stage ----------------
    // Fill phase takes beats for runs below eff; wait phase takes only the
    // awaited run. Anything else is dropped without a result.
    assign fill_ph  = r_fill < eff;
    assign in_rng   = {1'b0, r_in_idx} < eff;
    assign fill_inc = r_fill + CNT_W'(1);
    assign wr       = r_in_valid && adv && (fill_ph ? in_rng : (r_in_idx == r_await));
    assign emit     = wr && (fill_ph ? (fill_inc == eff) : 1'b1);

    // heads as they stand after this beat; the tree sees the new word directly
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            if (wr && (r_in_idx == IDX_W'(j))) begin
                n_valid[j] = !r_in_exh;
                n_word[j]  = r_in_exh ? r_word[j] : r_in_val;
            end else begin
                n_valid[j] = r_valid[j];
                n_word[j]  = r_word[j];
            end
            lane_on[j] = CNT_W'(j) < eff;
        end
    end

    kwrm_min_tree #(
        .N_LEAF (SLOTS)
    ) u_min_tree (
        .i_valid (n_valid & lane_on),
        .i_word  (n_word),
        .o_best  (best)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= RUN_COUNT_RST;
            r_valid     <= '0;
            r_fill      <= '0;
            r_await     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // new run count opens a new merge
                r_run_count <= i_cfg_data;
                r_valid     <= '0;
                r_fill      <= '0;
            end else if (emit && !best.vld) begin
                // all runs drained: done result, back to fill phase
                r_valid <= '0;
                r_fill  <= '0;
            end else begin
                r_valid <= n_valid;
                if (wr && fill_ph) begin
                    r_fill <= fill_inc;
                end
            end

            if (emit) begin
                r_await <= best.vld ? best.idx : '0;
            end

            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SLOTS; j++) begin
            r_word[j] <= n_word[j];
        end
        if (in_acc) begin
            r_in_idx <= i_in.run_index;
            r_in_val <= i_in.run_value;
            r_in_exh <= i_in.exhausted;
        end
        if (emit) begin
            r_out_val  <= best.vld ? best.val : '0;
            r_out_idx  <= best.vld ? best.idx : '0;
            r_out_done <= !best.vld;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_value  = r_out_val;
    assign o_out.refill_run = r_out_idx;
    assign o_out.done_res   = r_out_done;

    // ---------------- assertions ----------------
    `KWRM_ASSERT_ALW(a_fill_bound, r_fill <= eff)
    `KWRM_ASSERT_IMP(a_await_match, r_out_valid && !r_out_done, r_await == r_out_idx)
    `KWRM_ASSERT_IMP(a_no_overrun, r_out_valid && !o_out.ready, !emit)
    `KWRM_ASSERT_NXT(a_done_clears, emit && !best.vld && !i_cfg_we, r_valid == '0 && r_fill == '0)

endmodule
